// ----- rtl/codec_verb_table_search_unit_defines.svh -----
// Assertion macros shared by the RTL of the codec verb table search unit.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef CODEC_VERB_TABLE_SEARCH_UNIT_DEFINES_SVH
`define CODEC_VERB_TABLE_SEARCH_UNIT_DEFINES_SVH

// Plain property, checked on every rising clock edge outside reset.
`define CVTS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define CVTS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CVTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/cvts_pkg.sv -----
package cvts_pkg;

	// Default number of 32-bit words in the record memory.
	localparam int TABLE_DEPTH_DEFAULT = 1024;

	localparam int WORD_W   = 32;
	localparam int INDEX_W  = 10;
	localparam int COUNT_W  = 11;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_SEARCH = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_ID,
		S_RD_CNT,
		S_EVAL,
		S_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // write one table word
		logic start;    // capture the query id and rewind the walk
		logic rd_id;    // read the id word of the current header
		logic rd_cnt;   // read the jack count word, register the id compare
		logic hit;      // record the current header as the match
		logic miss;     // record a not-found result
		logic advance;  // step to the next header
		logic publish;  // move the result into the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic hdr_ok;   // the whole header at the current position is loaded
		logic next_ok;  // the following header lies inside the loaded table
		logic match;    // the id word equals the query
		logic out_busy; // the output register still holds an untaken result
	} status_t;

endpackage

// ----- rtl/cvts_ctrl.sv -----
`include "codec_verb_table_search_unit_defines.svh"

module cvts_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_opcode,
	output logic             in_ready,
	input  cvts_pkg::status_t status,
	output cvts_pkg::cmd_t   cmd
);

	cvts_pkg::state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cvts_pkg::S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		unique case (state_q)
			cvts_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_opcode == cvts_pkg::OP_SEARCH) begin
						cmd.start  = 1'b1;
						state_next = cvts_pkg::S_RD_ID;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			cvts_pkg::S_RD_ID: begin
				if (status.hdr_ok) begin
					cmd.rd_id  = 1'b1;
					state_next = cvts_pkg::S_RD_CNT;
				end else begin
					cmd.miss   = 1'b1;
					state_next = cvts_pkg::S_DONE;
				end
			end
			cvts_pkg::S_RD_CNT: begin
				cmd.rd_cnt = 1'b1;
				state_next = cvts_pkg::S_EVAL;
			end
			cvts_pkg::S_EVAL: begin
				if (status.match) begin
					cmd.hit    = 1'b1;
					state_next = cvts_pkg::S_DONE;
				end else if (status.next_ok) begin
					cmd.advance = 1'b1;
					state_next  = cvts_pkg::S_RD_ID;
				end else begin
					cmd.miss   = 1'b1;
					state_next = cvts_pkg::S_DONE;
				end
			end
			cvts_pkg::S_DONE: begin
				if (!status.out_busy) begin
					cmd.publish = 1'b1;
					state_next  = cvts_pkg::S_IDLE;
				end
			end
			default: begin
				state_next = cvts_pkg::S_IDLE;
			end
		endcase
	end

	`CVTS_ASSERT_IMPL(a_publish_free, cmd.publish, !status.out_busy, "result published over a pending one")
	`CVTS_ASSERT_NEXT(a_search_walks, in_valid && in_ready && in_opcode == cvts_pkg::OP_SEARCH, state_q == cvts_pkg::S_RD_ID, "accepted search did not start the walk")
	`CVTS_ASSERT_IMPL(a_cnt_after_id, state_q == cvts_pkg::S_RD_CNT, $past(state_q) == cvts_pkg::S_RD_ID, "count read without an id read")

endmodule

// ----- rtl/cvts_dp.sv -----
`include "codec_verb_table_search_unit_defines.svh"

module cvts_dp #(
	parameter int TABLE_DEPTH = cvts_pkg::TABLE_DEPTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cvts_pkg::COUNT_W-1:0]  cfg_value,
	input  logic [cvts_pkg::INDEX_W-1:0]  load_index,
	input  logic [cvts_pkg::WORD_W-1:0]   load_word,
	input  logic [cvts_pkg::WORD_W-1:0]   query_id,
	input  cvts_pkg::cmd_t                cmd,
	output cvts_pkg::status_t             status,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          out_found,
	output logic [cvts_pkg::INDEX_W-1:0]  out_start,
	output logic [cvts_pkg::COUNT_W-1:0]  out_count
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = cvts_pkg::COUNT_W;

	logic [cvts_pkg::WORD_W-1:0] mem [TABLE_DEPTH];
	logic [cvts_pkg::WORD_W-1:0] rdata_q;
	logic [cvts_pkg::WORD_W-1:0] query_q;
	logic [CW-1:0]               table_words_q;
	logic [CW-1:0]               pos_q;
	logic                        match_q;

	logic                        res_found_q;
	logic [cvts_pkg::INDEX_W-1:0] res_start_q;
	logic [CW-1:0]               res_count_q;

	logic                        out_valid_q;
	logic                        out_found_q;
	logic [cvts_pkg::INDEX_W-1:0] out_start_q;
	logic [CW-1:0]               out_count_q;

	logic [CW-1:0]               limit;
	logic [CW-1:0]               rd_pos;
	logic [AW-1:0]               rd_addr;
	logic                        rd_en;
	logic                        load_ok;
	logic                        span_big;
	logic [CW-1:0]               span4;
	logic [CW-1:0]               start;
	logic [CW-1:0]               left;
	logic [CW-1:0]               count;
	logic [CW+1:0]               next_pos;

	assign limit = (32'(table_words_q) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : table_words_q;

	// Header checks and the span arithmetic on the jack count word.
	assign span_big = |rdata_q[cvts_pkg::WORD_W-1:CW-2];
	assign span4    = {rdata_q[CW-3:0], 2'b00};
	assign start    = pos_q + CW'(3);
	assign left     = limit - start;
	assign count    = (span_big || span4 > left) ? left : span4;
	assign next_pos = (CW+2)'(pos_q) + (CW+2)'(span4) + (CW+2)'(3);

	assign status.hdr_ok   = ((CW+1)'(pos_q) + (CW+1)'(2)) < (CW+1)'(limit);
	assign status.next_ok  = !span_big && ((next_pos + (CW+2)'(2)) < (CW+2)'(limit));
	assign status.match    = match_q;
	assign status.out_busy = out_valid_q && !out_ready;

	assign rd_en   = cmd.rd_id || cmd.rd_cnt;
	assign rd_pos  = cmd.rd_cnt ? pos_q + CW'(2) : pos_q;
	assign rd_addr = AW'(rd_pos);
	assign load_ok = cmd.load && (32'(load_index) < TABLE_DEPTH);

	always_ff @(posedge clk) begin
		if (load_ok) begin
			mem[AW'(load_index)] <= load_word;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_words_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				table_words_q <= cfg_value;
			end
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			query_q <= query_id;
			pos_q   <= '0;
		end else if (cmd.advance) begin
			pos_q <= next_pos[CW-1:0];
		end
		if (cmd.rd_cnt) begin
			match_q <= (rdata_q == query_q);
		end
		if (cmd.hit) begin
			res_found_q <= 1'b1;
			res_start_q <= start[cvts_pkg::INDEX_W-1:0];
			res_count_q <= count;
		end else if (cmd.miss) begin
			res_found_q <= 1'b0;
			res_start_q <= '0;
			res_count_q <= '0;
		end
		if (cmd.publish) begin
			out_found_q <= res_found_q;
			out_start_q <= res_start_q;
			out_count_q <= res_count_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_found = out_found_q;
	assign out_start = out_start_q;
	assign out_count = out_count_q;

	`CVTS_ASSERT_IMPL(a_rd_in_range, rd_en, 32'(rd_pos) < TABLE_DEPTH, "memory read beyond the table")
	`CVTS_ASSERT_IMPL(a_hit_in_table, cmd.hit, ((CW+1)'(start) + (CW+1)'(count)) <= (CW+1)'(limit), "match reaches past the loaded words")

endmodule

// ----- rtl/codec_verb_table_search_unit.sv -----
// Codec verb table search unit. The block holds a table of 32-bit words made of
// codec records: a three-word header (vendor/device id, subsystem id, jack
// count) followed by four verb words per jack. An input transfer with tuser low
// writes one table word; indexes at or past TABLE_DEPTH are dropped. An input
// transfer with tuser high searches for a vendor/device id by walking the
// headers from index 0 and returns exactly one result transfer: found, the
// index of the first verb word and the verb count, clamped to the words left
// in the walkable table, or all zeros when no record matches. The walk covers
// the first min(table_words, TABLE_DEPTH) words, and a header that does not
// fit in that range ends the walk as not found. The record memory has a single
// read port, so each header visited passes through an id read, a count read
// and an evaluation. No new input transfer is accepted until a search has
// finished its walk and moved its result into the output register, which
// waits for the previous result to be taken. Loads can be accepted while a
// result waits in the output register. Table entries come up undefined after
// reset; a search must only walk words that were loaded. Write table_words
// only while the block is idle.
module codec_verb_table_search_unit #(
	parameter int TABLE_DEPTH = cvts_pkg::TABLE_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,

	// Configuration: table_words, the number of loaded words a search may walk.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,  // load_index[9:0], load_word[41:10], query_id[73:42]
	input  logic        s_axis_tuser,  // opcode[0]

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // found[0], verb_start[10:1], verb_count[21:11]
);

	cvts_pkg::cmd_t    cmd;
	cvts_pkg::status_t status;

	logic                        out_found;
	logic [cvts_pkg::INDEX_W-1:0] out_start;
	logic [cvts_pkg::COUNT_W-1:0] out_count;

	// The register is a plain flop, so a configuration transfer completes at once.
	assign cfg_ready = 1'b1;

	cvts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_opcode(s_axis_tuser),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	cvts_dp #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_value (cfg_data),
		.load_index(s_axis_tdata[9:0]),
		.load_word (s_axis_tdata[41:10]),
		.query_id  (s_axis_tdata[73:42]),
		.cmd       (cmd),
		.status    (status),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_found (out_found),
		.out_start (out_start),
		.out_count (out_count)
	);

	assign m_axis_tdata = {2'b00, out_count, out_start, out_found};

endmodule

// ----- tb/tb_codec_verb_table_search_unit.sv -----
module tb_codec_verb_table_search_unit;

	localparam int DEPTH = cvts_pkg::TABLE_DEPTH_DEFAULT;

	// One search outcome as it travels on the result stream.
	typedef struct packed {
		logic        found;
		logic [9:0]  verb_start;
		logic [10:0] verb_count;
	} search_result_t;

	// Keeps its own copy of the record memory and of table_words, walks the
	// records for every accepted search and checks the result stream in order.
	class search_scoreboard;
		logic [31:0]    store [DEPTH];
		logic [10:0]    table_words = '0;
		search_result_t expected [$];
		int unsigned    mismatches = 0;
		int unsigned    checked = 0;
		int unsigned    hits = 0;

		function void set_table_words(logic [10:0] value);
			table_words = value;
		endfunction

		// Header walk from index 0: id word, subsystem word, jack count word,
		// then four verb words per jack. The first id match wins.
		function search_result_t walk_records(logic [31:0] query);
			search_result_t res;
			longint unsigned limit, pos, span, first;
			res = '0;
			limit = (table_words > DEPTH) ? DEPTH : table_words;
			pos = 0;
			// A header whose count word is at or past the limit ends the walk.
			while (pos + 2 < limit) begin
				span = 4 * longint'(store[pos + 2]);
				if (store[pos] == query) begin
					first = pos + 3;
					// A record that runs past the limit is clamped; one whose header ends
					// exactly at the limit reports no verbs.
					if (span > limit - first)
						span = limit - first;
					res.found = 1'b1;
					res.verb_start = first[9:0];
					res.verb_count = span[10:0];
					return res;
				end
				pos += span + 3;
			end
			return res;
		endfunction

		function void note_item(cvts_pkg::opcode_t op, logic [9:0] index, logic [31:0] word,
				logic [31:0] query);
			if (op == cvts_pkg::OP_LOAD) begin
				if (index < DEPTH)
					store[index] = word;
			end else begin
				expected.push_back(walk_records(query));
			end
		endfunction

		function void check_result(logic [23:0] data);
			search_result_t want, got;
			got.found = data[0];
			got.verb_start = data[10:1];
			got.verb_count = data[21:11];
			checked++;
			if (expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Result %0d arrived with no search pending: found=%0d start=%0d count=%0d",
						checked, got.found, got.verb_start, got.verb_count);
				return;
			end
			want = expected.pop_front();
			if (got.found !== want.found || got.verb_start !== want.verb_start ||
					got.verb_count !== want.verb_count) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Mismatch on result %0d: expected found=%0d start=%0d count=%0d, got found=%0d start=%0d count=%0d",
						checked, want.found, want.verb_start, want.verb_count,
						got.found, got.verb_start, got.verb_count);
			end else if (got.found) begin
				hits++;
			end
		endfunction

		function int pending();
			return expected.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [10:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata;   // load_index[9:0], load_word[41:10], query_id[73:42]
	logic        s_axis_tuser;   // opcode[0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;   // found[0], verb_start[10:1], verb_count[21:11]

	search_scoreboard sb = new;

	// Table image that the stimulus builds before loading it word by word.
	logic [31:0] image [DEPTH];
	// Length of the prefix of the table that has been loaded at least once;
	// the words a search may walk never go beyond it, so no search reads an unwritten word.
	int          loaded_len = 0;

	// Idling controls shared by the sender and the receiver processes.
	bit          src_idle = 1'b0;
	bit          snk_idle = 1'b0;
	bit          long_hold = 1'b0;

	int unsigned n_loads = 0;
	int unsigned n_searches = 0;
	int unsigned n_limits = 0;

	codec_verb_table_search_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #4 clk = ~clk;

	// Both monitors sample at the rising edge, before any nonblocking update
	// of that edge, so they see exactly the values of the completed transfer.
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_item(cvts_pkg::opcode_t'(s_axis_tuser), s_axis_tdata[9:0],
				s_axis_tdata[41:10], s_axis_tdata[73:42]);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	// Result receiver. A long hold-off lets the block fill its output register
	// and back up into its input; otherwise short random stalls when enabled.
	initial begin : result_sink
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (300) @(posedge clk);
			end else if (snk_idle && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// Offers one item and returns at the edge where the transfer completes,
	// with tvalid still high so that the next item can follow back to back.
	task automatic send_item(input cvts_pkg::opcode_t op, input logic [9:0] index,
			input logic [31:0] word, input logic [31:0] query);
		int gap;
		if (src_idle && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 6);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {6'd0, query, word, index};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// The unused fields carry random junk so their input bits toggle.
	task automatic send_load(input int index, input logic [31:0] word);
		send_item(cvts_pkg::OP_LOAD, index[9:0], word, $urandom);
		n_loads++;
	endtask

	task automatic send_search(input logic [31:0] query);
		send_item(cvts_pkg::OP_SEARCH, 10'($urandom), $urandom, query);
		n_searches++;
	endtask

	// Stops offering and waits until every search has answered. Loads give no
	// result, so an extra idle wait lets the last one settle.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (10) @(posedge clk);
	endtask

	// table_words only changes while the block is idle.
	task automatic write_table_words(input logic [10:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		sb.set_table_words(value);
		n_limits++;
	endtask

	// Loads image[0 .. len-1] in a shuffled order, now and then writing a word
	// twice.
	task automatic load_image(input int len);
		int order [$];
		int j, tmp;
		for (int i = 0; i < len; i++)
			order.push_back(i);
		for (int i = len - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		foreach (order[i]) begin
			send_load(order[i], image[order[i]]);
			if ($urandom_range(0, 15) == 0)
				send_load(order[i], image[order[i]]);
		end
	endtask

	// Fills image[0 .. len-1] with a chain of records whose ids come from a
	// small pool, so repeats and first-match ordering show up. Most records
	// have a few jacks; some have huge counts that end the chain at once.
	task automatic build_records(input int len, input logic [31:0] pool [4]);
		longint pos;
		logic [31:0] jacks;
		int r;
		for (int i = 0; i < len; i++)
			image[i] = $urandom;
		pos = 0;
		while (pos < len) begin
			r = $urandom_range(0, 19);
			if (r < 3)
				jacks = 32'd0;
			else if (r < 16)
				jacks = $urandom_range(1, 4);
			else if (r == 16)
				jacks = 32'hFFFF_FFFF;
			else if (r == 17)
				jacks = 32'h4000_0000;
			else
				jacks = $urandom;
			image[pos] = pool[$urandom_range(0, 3)];
			if (pos + 2 < len)
				image[pos + 2] = jacks;
			pos += 3 + 4 * longint'(jacks);
		end
	endtask

	// Hand-built table covering the listed corner cases on a 15-word table.
	task automatic run_directed();
		write_table_words(11'd0);
		send_search(32'h0000_0000);            // empty table, nothing to walk
		for (int i = 0; i < 15; i++)
			image[i] = $urandom;
		image[0] = 32'h0000_0000;              // zero jacks
		image[2] = 32'd0;
		image[3] = 32'h1234_5678;              // one jack, fully inside
		image[5] = 32'd1;
		image[10] = 32'hFFFF_FFFF;             // two jacks, runs past the end
		image[12] = 32'd2;
		write_table_words(11'd15);
		load_image(15);
		loaded_len = 15;
		send_search(32'h0000_0000);
		send_search(32'h1234_5678);
		send_search(32'hFFFF_FFFF);
		send_search(32'hDEAD_BEEF);            // walks off the end, not found
		write_table_words(11'd13);
		send_search(32'hFFFF_FFFF);            // match header ends exactly at the limit
		write_table_words(11'd12);
		send_search(32'hFFFF_FFFF);            // its header is now truncated
		send_search(32'h1234_5678);
		write_table_words(11'd2);
		send_search(32'h0000_0000);            // even the first header is cut off
	endtask

	// Full 1024-word table with headers at 0, 1003, 1018 and 1021, so the last
	// match starts exactly at the table end and its start index wraps to 0.
	task automatic run_full_table();
		logic [31:0] ids [4];
		logic [10:0] limits [4];
		foreach (ids[i])
			ids[i] = $urandom;
		for (int i = 0; i < DEPTH; i++)
			image[i] = $urandom;
		image[0] = ids[0];
		image[2] = 32'd250;
		image[1003] = ids[1];
		image[1005] = 32'd3;
		image[1018] = ids[2];
		image[1020] = 32'd0;
		image[1021] = ids[3];
		write_table_words(11'd1024);
		load_image(DEPTH);
		loaded_len = DEPTH;
		// Full table, last header truncated, limit above the depth, and a limit
		// that clamps the first, very long record.
		limits = '{11'd1024, 11'd1023, 11'd2047, 11'd1000};
		foreach (limits[s]) begin
			if (s != 0)
				write_table_words(limits[s]);
			foreach (ids[i])
				send_search(ids[i]);
			send_search($urandom);
		end
	endtask

	// One random phase: build and load a table, pick a limit, then search
	// with loads mixed in. The squeeze phase holds off the receiver and later
	// pauses the sender until all results are in.
	task automatic run_phase(input bit squeeze);
		logic [31:0] pool [4];
		logic [31:0] word;
		int len, tw, cap, searches, r, index;
		r = $urandom_range(0, 9);
		if (r < 6)
			len = $urandom_range(1, 40);
		else if (r < 9)
			len = $urandom_range(41, 160);
		else
			len = $urandom_range(161, 400);
		searches = squeeze ? 12 : $urandom_range(4, 16);
		foreach (pool[i])
			pool[i] = $urandom;
		r = $urandom_range(0, 5);
		if (r == 0)
			pool[0] = 32'h0000_0000;
		else if (r == 1)
			pool[0] = 32'hFFFF_FFFF;
		build_records(len, pool);
		if (len > loaded_len)
			loaded_len = len;
		// Once the whole table has been loaded, any 11-bit limit is legal.
		cap = (loaded_len >= DEPTH) ? 2047 : loaded_len;
		r = $urandom_range(0, 9);
		if (r < 5)
			tw = len;
		else if (r < 7)
			tw = len - $urandom_range(0, (len < 3) ? len : 3);
		else if (r < 9)
			tw = $urandom_range(0, cap);
		else
			tw = $urandom_range(0, (cap < 3) ? cap : 3);
		write_table_words(11'(tw));
		load_image(len);
		for (int k = 0; k < searches; k++) begin
			if (squeeze && k == 1)
				long_hold = 1'b1;
			if (squeeze ? (k == 8) : (k == searches / 2 && $urandom_range(0, 3) == 0))
				drain_results();
			if ($urandom_range(0, 3) == 0) begin
				index = $urandom_range(0, len - 1);
				word = ($urandom_range(0, 9) < 7) ? image[index] : $urandom;
				image[index] = word;
				send_load(index, word);
			end
			send_search(($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 3)] : $urandom);
		end
	endtask

	initial begin : stimulus
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= cvts_pkg::OP_LOAD;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		// Random part: small tables first, then the full table, then small
		// tables again on top of the stale full-table contents.
		src_idle = 1'b1;
		snk_idle = 1'b1;
		run_phase(1'b1);
		while (n_loads + n_searches < 500) begin
			src_idle = ($urandom_range(0, 3) != 0);
			snk_idle = ($urandom_range(0, 3) != 0);
			run_phase(1'b0);
		end
		run_full_table();
		while (n_loads + n_searches < 1750) begin
			src_idle = ($urandom_range(0, 3) != 0);
			snk_idle = ($urandom_range(0, 3) != 0);
			run_phase(1'b0);
		end
		// Closing stretch at full rate on both sides.
		src_idle = 1'b0;
		snk_idle = 1'b0;
		while (n_loads + n_searches < 1900)
			run_phase(1'b0);

		drain_results();
		repeat (40) @(posedge clk);
		$display("Covered %0d word loads and %0d searches (%0d found) across %0d table_words values.",
			n_loads, n_searches, sb.hits, n_limits);
		$display("%0d results checked, %0d mismatches, %0d searches unanswered.",
			sb.checked, sb.mismatches, sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Far beyond the slowest legal run, with every search walking the most
	// headers and every transfer waiting out the longest stalls.
	initial begin : watchdog
		#200_000_000;
		$display("Timeout: the run did not finish.");
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- codec_verb_table_search_unit.f -----
+incdir+rtl
rtl/cvts_pkg.sv
rtl/cvts_ctrl.sv
rtl/cvts_dp.sv
rtl/codec_verb_table_search_unit.sv
tb/tb_codec_verb_table_search_unit.sv
